// ===== design/dsc_pkg.sv =====
package dsc_pkg;

  localparam int CNT_W   = 6;
  localparam int POS_W   = 10;
  localparam int PW_DEPTH = 1024;
  localparam int ACC_W   = 40;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    REG_MAP_SIZE = 2'd0,
    REG_IN_CH    = 2'd1,
    REG_OUT_CH   = 2'd2,
    REG_FRAC     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_DW_WEIGHT = 3'd0,
    CMD_DW_BIAS   = 3'd1,
    CMD_PW_WEIGHT = 3'd2,
    CMD_PW_BIAS   = 3'd3,
    CMD_SAMPLE    = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DW,
    BK_DW_DRAIN,
    BK_PW,
    BK_PW_ISSUE
  } bk_state_t;

  typedef struct packed {
    logic [POS_W-1:0] size;
    logic [CNT_W-1:0] nin;
    logic [CNT_W-1:0] nout;
    logic [3:0]       frac;
  } cfg_t;

  typedef struct packed {
    cmd_t             kind;
    logic [9:0]       idx;
    logic [15:0]      val;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [CNT_W-1:0] ch;
    logic [1:0]       slot;
    logic             fire;
  } q_entry_t;

endpackage

// ===== design/dsc_cfg.sv =====
module dsc_cfg #(
  parameter int MAX_MAP_SIZE = 512,
  parameter int MAX_CHANNELS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output dsc_pkg::cfg_t cfg
);

  localparam int CH_LIM = (MAX_CHANNELS < 32) ? MAX_CHANNELS : 32;

  logic [9:0] map_r;
  logic [5:0] nin_r;
  logic [5:0] nout_r;
  logic [3:0] frac_r;
  dsc_pkg::reg_idx_t sel;

  assign sel = dsc_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r  <= 10'd257;
      nin_r  <= 6'd16;
      nout_r <= 6'd16;
      frac_r <= 4'd8;
    end else if (psel && penable && pwrite) begin
      case (sel)
        dsc_pkg::REG_MAP_SIZE: map_r  <= pwdata[9:0];
        dsc_pkg::REG_IN_CH:    nin_r  <= pwdata[5:0];
        dsc_pkg::REG_OUT_CH:   nout_r <= pwdata[5:0];
        dsc_pkg::REG_FRAC:     frac_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      dsc_pkg::REG_MAP_SIZE: prdata = {22'd0, map_r};
      dsc_pkg::REG_IN_CH:    prdata = {26'd0, nin_r};
      dsc_pkg::REG_OUT_CH:   prdata = {26'd0, nout_r};
      dsc_pkg::REG_FRAC:     prdata = {28'd0, frac_r};
      default:               prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (map_r < 10'd3) cfg.size = 10'd3;
    else if (int'(map_r) > MAX_MAP_SIZE) cfg.size = 10'(MAX_MAP_SIZE);
    else cfg.size = map_r;
    if (nin_r == 6'd0) cfg.nin = 6'd1;
    else if (int'(nin_r) > CH_LIM) cfg.nin = 6'(CH_LIM);
    else cfg.nin = nin_r;
    if (nout_r == 6'd0) cfg.nout = 6'd1;
    else if (int'(nout_r) > CH_LIM) cfg.nout = 6'(CH_LIM);
    else cfg.nout = nout_r;
    cfg.frac = frac_r;
  end

endmodule

// ===== design/dsc_front.sv =====
module dsc_front #(
  parameter int MAX_CHANNELS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dsc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_command,
  input  logic [9:0]        in_table_index,
  input  logic signed [15:0] in_value,
  input  logic              q_full,
  output logic              q_push,
  output dsc_pkg::q_entry_t q_data
);

  logic [dsc_pkg::POS_W-1:0] row_r, col_r, row_nxt, col_nxt, r, c;
  logic [dsc_pkg::CNT_W-1:0] chan_r, chan_nxt, ch;
  logic [1:0] rm3_r, rm3_nxt, rm;
  logic       acc, keep, last_ch;

  assign in_ready = !q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    r  = (row_r >= cfg.size) ? '0 : row_r;
    rm = (row_r >= cfg.size) ? 2'd0 : rm3_r;
    c  = (col_r >= cfg.size) ? '0 : col_r;
    ch = (chan_r >= cfg.nin) ? '0 : chan_r;
    last_ch = (ch + 6'd1) >= cfg.nin;

    // drop unknown commands and out-of-range table writes
    case (in_command)
      dsc_pkg::CMD_DW_WEIGHT: keep = int'(in_table_index) < MAX_CHANNELS * 9;
      dsc_pkg::CMD_DW_BIAS,
      dsc_pkg::CMD_PW_BIAS:   keep = int'(in_table_index) < MAX_CHANNELS;
      dsc_pkg::CMD_PW_WEIGHT,
      dsc_pkg::CMD_SAMPLE:    keep = 1'b1;
      default:                keep = 1'b0;
    endcase

    q_push      = acc && keep;
    q_data.kind = dsc_pkg::cmd_t'(in_command);
    q_data.idx  = in_table_index;
    q_data.val  = in_value;
    q_data.row  = r;
    q_data.col  = c;
    q_data.ch   = ch;
    q_data.slot = rm;
    q_data.fire = last_ch && (r >= 10'd2) && (c >= 10'd2) && !r[0] && !c[0];

    row_nxt  = r;
    col_nxt  = c;
    rm3_nxt  = rm;
    chan_nxt = ch + 6'd1;
    if (last_ch) begin
      chan_nxt = '0;
      if ({1'b0, c} + 11'd1 >= {1'b0, cfg.size}) begin
        col_nxt = '0;
        if ({1'b0, r} + 11'd1 >= {1'b0, cfg.size}) begin
          row_nxt = '0;
          rm3_nxt = 2'd0;
        end else begin
          row_nxt = r + 10'd1;
          rm3_nxt = (rm == 2'd2) ? 2'd0 : rm + 2'd1;
        end
      end else begin
        col_nxt = c + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      chan_r <= '0;
      rm3_r  <= '0;
    end else if (acc && in_command == dsc_pkg::CMD_SAMPLE) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      chan_r <= chan_nxt;
      rm3_r  <= rm3_nxt;
    end
  end

endmodule

// ===== design/dsc_queue.sv =====
module dsc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dsc_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output dsc_pkg::q_entry_t rdata
);

  dsc_pkg::q_entry_t mem_r [dsc_pkg::Q_DEPTH];
  logic [dsc_pkg::Q_AW-1:0] wp_r, rp_r;
  logic [dsc_pkg::Q_AW:0]   cnt_r;

  assign full  = cnt_r == (dsc_pkg::Q_AW+1)'(dsc_pkg::Q_DEPTH);
  assign valid = cnt_r != '0;
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (dsc_pkg::Q_AW+1)'(push) - (dsc_pkg::Q_AW+1)'(pop);
    end
  end

endmodule

// ===== design/dsc_back.sv =====
module dsc_back #(
  parameter int MAX_MAP_SIZE = 512,
  parameter int MAX_CHANNELS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dsc_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  dsc_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [14:0]       out_value,
  output logic [7:0]        out_row,
  output logic [7:0]        out_col,
  output logic [4:0]        out_channel,
  output logic              out_last_of_window
);

  localparam int LS_ROW   = MAX_MAP_SIZE * MAX_CHANNELS;
  localparam int LS_DEPTH = 3 * LS_ROW;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int DWW_DEPTH = MAX_CHANNELS * 9;
  localparam int DWW_AW   = $clog2(DWW_DEPTH);
  localparam int CHA_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ACC_W    = dsc_pkg::ACC_W;

  logic [15:0] ls_mem  [LS_DEPTH];
  logic [15:0] dww_mem [DWW_DEPTH];
  logic [15:0] dwb_mem [MAX_CHANNELS];
  logic [15:0] pww_mem [dsc_pkg::PW_DEPTH];
  logic [15:0] pwb_mem [MAX_CHANNELS];
  logic [15:0] dwr_mem [MAX_CHANNELS];

  logic [15:0] ls_rd_r, dww_rd_r, dwb_rd_r, pww_rd_r, pwb_rd_r, dwr_rd_r;

  dsc_pkg::bk_state_t state_r, state_nxt;
  logic [dsc_pkg::CNT_W-1:0] ch_r, ch_nxt, oc_r, oc_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [1:0]  kw_r, kw_nxt, slot_r, slot_nxt, slot0_r, slot0_nxt;
  logic [DWW_AW-1:0] dwi_r, dwi_nxt;
  logic [dsc_pkg::POS_W-1:0] colb_r, colb_nxt;
  logic [7:0]  wrow_r, wrow_nxt, wcol_r, wcol_nxt;
  logic [dsc_pkg::POS_W-1:0] rm2, cm2;

  logic        iss, iss_first, iss_last, iss_mode;
  logic [dsc_pkg::CNT_W-1:0] iss_ch;
  logic [LS_AW-1:0] ls_ra;
  logic [dsc_pkg::POS_W-1:0] ls_col;
  logic        wr_en;

  logic        v1_r, f1_r, l1_r, m1_r, v2_r, f2_r, l2_r, m2_r;
  logic [dsc_pkg::CNT_W-1:0] c1_r, c2_r;
  logic signed [15:0] mul_a, mul_b, bias1;
  logic signed [31:0] prod_r;
  logic signed [15:0] bias2_r;
  logic signed [ACC_W-1:0] acc_r, sh, sum;
  logic [14:0] rs;
  logic        out_valid_r;
  logic [14:0] out_value_r;
  logic [7:0]  out_row_r, out_col_r;
  logic [4:0]  out_ch_r;
  logic        out_last_r;

  assign wr_en = (state_r == dsc_pkg::BK_IDLE) && q_valid;
  assign ls_col = colb_r + dsc_pkg::POS_W'(kw_r);
  assign ls_ra  = LS_AW'(int'(slot_r) * LS_ROW + int'(ls_col) * MAX_CHANNELS + int'(ch_r));

  // table and line store writes come from the queue head, reads from the sequencer
  always_ff @(posedge clk) begin
    if (wr_en && q_head.kind == dsc_pkg::CMD_SAMPLE)
      ls_mem[LS_AW'(int'(q_head.slot) * LS_ROW + int'(q_head.col) * MAX_CHANNELS
                    + int'(q_head.ch))] <= q_head.val;
    ls_rd_r <= ls_mem[ls_ra];
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_head.kind == dsc_pkg::CMD_DW_WEIGHT)
      dww_mem[DWW_AW'(q_head.idx)] <= q_head.val;
    dww_rd_r <= dww_mem[dwi_r];
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_head.kind == dsc_pkg::CMD_DW_BIAS)
      dwb_mem[CHA_W'(q_head.idx)] <= q_head.val;
    dwb_rd_r <= dwb_mem[CHA_W'(ch_r)];
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_head.kind == dsc_pkg::CMD_PW_WEIGHT)
      pww_mem[q_head.idx] <= q_head.val;
    pww_rd_r <= pww_mem[{ch_r[4:0], oc_r[4:0]}];
  end

  always_ff @(posedge clk) begin
    if (wr_en && q_head.kind == dsc_pkg::CMD_PW_BIAS)
      pwb_mem[CHA_W'(q_head.idx)] <= q_head.val;
    pwb_rd_r <= pwb_mem[CHA_W'(oc_r)];
  end

  always_ff @(posedge clk) begin
    if (v2_r && l2_r && !m2_r) dwr_mem[CHA_W'(c2_r)] <= {1'b0, rs};
    dwr_rd_r <= dwr_mem[CHA_W'(ch_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dsc_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    oc_r    <= oc_nxt;
    k_r     <= k_nxt;
    kw_r    <= kw_nxt;
    slot_r  <= slot_nxt;
    slot0_r <= slot0_nxt;
    dwi_r   <= dwi_nxt;
    colb_r  <= colb_nxt;
    wrow_r  <= wrow_nxt;
    wcol_r  <= wcol_nxt;
  end

  assign rm2 = q_head.row - 10'd2;
  assign cm2 = q_head.col - 10'd2;

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    oc_nxt    = oc_r;
    k_nxt     = k_r;
    kw_nxt    = kw_r;
    slot_nxt  = slot_r;
    slot0_nxt = slot0_r;
    dwi_nxt   = dwi_r;
    colb_nxt  = colb_r;
    wrow_nxt  = wrow_r;
    wcol_nxt  = wcol_r;
    q_pop     = 1'b0;
    iss       = 1'b0;
    iss_first = 1'b0;
    iss_last  = 1'b0;
    iss_mode  = 1'b0;
    iss_ch    = ch_r;
    case (state_r)
      dsc_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.kind == dsc_pkg::CMD_SAMPLE && q_head.fire) begin
            state_nxt = dsc_pkg::BK_DW;
            ch_nxt    = '0;
            k_nxt     = '0;
            kw_nxt    = '0;
            dwi_nxt   = '0;
            slot0_nxt = (q_head.slot == 2'd2) ? 2'd0 : q_head.slot + 2'd1;
            slot_nxt  = (q_head.slot == 2'd2) ? 2'd0 : q_head.slot + 2'd1;
            colb_nxt  = cm2;
            wrow_nxt  = rm2[8:1];
            wcol_nxt  = cm2[8:1];
          end
        end
      end
      dsc_pkg::BK_DW: begin
        iss       = 1'b1;
        iss_first = k_r == 4'd0;
        iss_last  = k_r == 4'd8;
        dwi_nxt   = dwi_r + 1'b1;
        if (k_r == 4'd8) begin
          k_nxt    = '0;
          kw_nxt   = '0;
          slot_nxt = slot0_r;
          ch_nxt   = ch_r + 6'd1;
          if (ch_r == cfg.nin - 6'd1) state_nxt = dsc_pkg::BK_DW_DRAIN;
        end else begin
          k_nxt = k_r + 4'd1;
          if (kw_r == 2'd2) begin
            kw_nxt   = '0;
            slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
          end else begin
            kw_nxt = kw_r + 2'd1;
          end
        end
      end
      dsc_pkg::BK_DW_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = dsc_pkg::BK_PW;
          oc_nxt    = '0;
        end
      end
      dsc_pkg::BK_PW: begin
        // start an output channel only once the result register is free
        if (!v1_r && !v2_r && !out_valid_r) begin
          state_nxt = dsc_pkg::BK_PW_ISSUE;
          ch_nxt    = '0;
        end
      end
      dsc_pkg::BK_PW_ISSUE: begin
        iss       = 1'b1;
        iss_mode  = 1'b1;
        iss_ch    = oc_r;
        iss_first = ch_r == '0;
        iss_last  = ch_r == cfg.nin - 6'd1;
        ch_nxt    = ch_r + 6'd1;
        if (iss_last) begin
          ch_nxt = '0;
          if (oc_r == cfg.nout - 6'd1) begin
            state_nxt = dsc_pkg::BK_IDLE;
          end else begin
            oc_nxt    = oc_r + 6'd1;
            state_nxt = dsc_pkg::BK_PW;
          end
        end
      end
      default: state_nxt = dsc_pkg::BK_IDLE;
    endcase
  end

  assign mul_a = m1_r ? $signed(dwr_rd_r) : $signed(ls_rd_r);
  assign mul_b = m1_r ? $signed(pww_rd_r) : $signed(dww_rd_r);
  assign bias1 = m1_r ? $signed(pwb_rd_r) : $signed(dwb_rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= iss;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_r    <= iss_first;
    l1_r    <= iss_last;
    m1_r    <= iss_mode;
    c1_r    <= iss_ch;
    f2_r    <= f1_r;
    l2_r    <= l1_r;
    m2_r    <= m1_r;
    c2_r    <= c1_r;
    prod_r  <= mul_a * mul_b;
    bias2_r <= bias1;
    if (v2_r) acc_r <= sum;
  end

  // floor shift of the product, accumulate from the bias on the first term, clamp to 0..32767
  always_comb begin
    sh  = ACC_W'(prod_r) >>> cfg.frac;
    sum = (f2_r ? ACC_W'(bias2_r) : acc_r) + sh;
    if (sum < 0) rs = '0;
    else if (sum > ACC_W'(32767)) rs = 15'h7fff;
    else rs = sum[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (v2_r && l2_r && m2_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && l2_r && m2_r) begin
      out_value_r <= rs;
      out_row_r   <= wrow_r;
      out_col_r   <= wcol_r;
      out_ch_r    <= c2_r[4:0];
      out_last_r  <= c2_r == cfg.nout - 6'd1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_value          = out_value_r;
  assign out_row            = out_row_r;
  assign out_col            = out_col_r;
  assign out_channel        = out_ch_r;
  assign out_last_of_window = out_last_r;

endmodule

// ===== design/depthwise_separable_conv_relu_top.sv =====
// Depthwise separable 3x3 stride-2 convolution with ReLU. Table loads (command 0..3) and map
// samples (command 4, raster order, channel innermost) enter a 4-entry queue; a back-end
// sequencer with one shared 16x16 multiply-accumulate unit executes them in order. A table load
// or a sample that completes no window is popped and written in the idle state. A sample that
// completes a window is popped, then issues nine depthwise taps per input channel and lets the
// pipeline drain, then per output channel issues nin pointwise terms after waiting for the
// pipeline and the output register to be free; each pointwise result waits for the output
// register to empty. Tables read undefined until loaded; no clearing pass is run after reset.
// Configuration is an APB register file: map_size, in_channels, out_channels, frac_bits at byte
// addresses 0, 4, 8, 12.
module depthwise_separable_conv_relu_top #(
  parameter int MAX_MAP_SIZE = 512,
  parameter int MAX_CHANNELS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [9:0]         in_table_index,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_value,
  output logic [7:0]         out_row,
  output logic [7:0]         out_col,
  output logic [4:0]         out_channel,
  output logic               out_last_of_window
);

  dsc_pkg::cfg_t     cfg;
  dsc_pkg::q_entry_t q_wdata, q_head;
  logic q_push, q_full, q_pop, q_valid;

  assign pready = 1'b1;

  dsc_cfg #(.MAX_MAP_SIZE(MAX_MAP_SIZE), .MAX_CHANNELS(MAX_CHANNELS)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  dsc_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk, .rst_n, .cfg, .in_valid, .in_ready, .in_command, .in_table_index, .in_value,
    .q_full, .q_push, .q_data(q_wdata)
  );

  dsc_queue u_queue (
    .clk, .rst_n, .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .valid(q_valid), .rdata(q_head)
  );

  dsc_back #(.MAX_MAP_SIZE(MAX_MAP_SIZE), .MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk, .rst_n, .cfg, .q_valid, .q_head, .q_pop,
    .out_valid, .out_ready, .out_value, .out_row, .out_col, .out_channel, .out_last_of_window
  );

endmodule
